/* hdl/streaming_inversion_counter_assert.svh */
// Assertion macros for the streaming inversion counter.
`ifndef STREAMING_INVERSION_COUNTER_ASSERT_SVH
`define STREAMING_INVERSION_COUNTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SIC_ASSERT_IMPL(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SIC_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* hdl/sic_pkg.sv */
// Shared constants and types of the streaming inversion counter.
package sic_pkg;

   localparam int VALUE_BITS    = 8;
   localparam int COUNT_BITS    = 16;
   localparam int GREATER_BITS  = 16;
   localparam int TOTAL_BITS    = 32;
   // one row holds the left and right child counts of one parent node
   localparam int ROW_BITS      = VALUE_BITS - 1;
   localparam int PAIR_BITS     = 2 * COUNT_BITS;
   localparam int ACC_SUM_BITS  = ((COUNT_BITS > GREATER_BITS) ? COUNT_BITS : GREATER_BITS) + 1;
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = GREATER_BITS + TOTAL_BITS;

   localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = '1;
   // min(count maximum, 0xFFFF)
   localparam logic [GREATER_BITS-1:0] GREATER_MAX = GREATER_BITS'(COUNT_MAX);

   // item walking down the chain of level cells
   typedef struct packed {
      logic                    valid;
      logic                    first;
      logic [VALUE_BITS-1:0]   value;
      logic [GREATER_BITS-1:0] acc;
      logic                    ovf;
   } item_type;

   // write request of a level cell to its row store
   typedef struct packed {
      logic                 en;
      logic [ROW_BITS-1:0]  row;
      logic [PAIR_BITS-1:0] data;
   } wr_type;

endpackage

/* hdl/streaming_inversion_counter.sv */
// Streaming inversion counter top level: launch control, level chain, totals, result queue.
// Each value runs down a chain of one cell per tree level below the root, each cell registering
// it in stage one and then in its output register; a new value is taken every cycle while
// no first value is held back for clearing and fewer than OUT_DEPTH results (20) are owed.
// A value with first set waits until the chain has drained, then all level stores are zeroed
// by a clearing pass before it enters; the same pass runs after reset, with req_tready low
// throughout. greater_before and total saturate; overflow is sticky per sequence.
`include "streaming_inversion_counter_assert.svh"

module streaming_inversion_counter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sic_pkg::REQ_DATA_BITS-1:0] req_tdata,   // value, zero padding
   input  logic [0:0]                        req_tuser,   // first
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sic_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // greater_before, total
   output logic [0:0]                        rsp_tuser    // overflow
);

   localparam int VB        = sic_pkg::VALUE_BITS;
   localparam int OUT_DEPTH = (2 * VB + 4 < 32) ? 2 * VB + 4 : 32;
   localparam int PTR_BITS  = $clog2(OUT_DEPTH);
   localparam int FCNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_DRAIN = 3'b010,
      ST_CLEAR = 3'b100
   } state_type;

   typedef struct packed {
      logic                             ovf;
      logic [sic_pkg::TOTAL_BITS-1:0]   total;
      logic [sic_pkg::GREATER_BITS-1:0] greater;
   } rsp_type;

   state_type                    state_ff, state_in;
   logic [sic_pkg::ROW_BITS-1:0] sweep_ff, sweep_in;
   logic                         cleared_ff, cleared_in;
   sic_pkg::item_type            lq_ff, lq_in;
   logic [FCNT_BITS-1:0]         outstanding_ff, outstanding_in;

   logic                         req_accept;
   logic                         rsp_accept;
   logic                         send;
   logic                         clearing;
   sic_pkg::item_type            chain [VB+1];
   logic [VB:1]                  busy_vec;

   // input side: hold register feeding the chain
   assign req_accept = req_tvalid & req_tready;
   assign clearing   = (state_ff == ST_CLEAR);
   assign send       = lq_ff.valid & (~lq_ff.first | cleared_ff) & (state_ff == ST_RUN);
   assign req_tready = (state_ff == ST_RUN) && (outstanding_ff < FCNT_BITS'(OUT_DEPTH))
                       && (!lq_ff.valid || send);

   always_comb begin
      lq_in = lq_ff;
      if (req_accept) begin
         lq_in.valid = 1'b1;
         lq_in.first = req_tuser[0];
         lq_in.value = req_tdata[VB-1:0];
         lq_in.acc   = '0;
         lq_in.ovf   = 1'b0;
      end else if (send) begin
         lq_in.valid = 1'b0;
      end
      chain[0]       = lq_ff;
      chain[0].valid = send;
   end

   // sequencer: drain the chain and sweep the stores ahead of a first value
   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      cleared_in = cleared_ff & ~send;
      unique case (state_ff)
         ST_RUN: begin
            if (lq_ff.valid && lq_ff.first && !cleared_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(|busy_vec)) begin
               state_in = ST_CLEAR;
               sweep_in = '0;
            end
         end
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in   = ST_RUN;
               cleared_in = lq_ff.valid;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            sweep_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         sweep_ff    <= '0;
         cleared_ff  <= 1'b0;
         lq_ff.valid <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         cleared_ff <= cleared_in;
         lq_ff      <= lq_in;
      end
   end

   // one cell and one row store per level below the root
   for (genvar lv = 1; lv <= VB; lv++) begin : g_level
      localparam int AW = (lv > 1) ? lv - 1 : 1;

      logic [sic_pkg::ROW_BITS-1:0]  row;
      logic                          side;
      logic [sic_pkg::PAIR_BITS-1:0] rd_data;
      sic_pkg::wr_type               wr;
      logic                          ram_wr_en;
      logic [AW-1:0]                 ram_wr_addr;
      logic [sic_pkg::PAIR_BITS-1:0] ram_wr_data;

      assign row  = sic_pkg::ROW_BITS'(chain[lv-1].value >> (VB - lv + 1));
      assign side = chain[lv-1].value[VB-lv];

      // the clearing pass takes over the write port
      assign ram_wr_en   = clearing | wr.en;
      assign ram_wr_addr = clearing ? sweep_ff[AW-1:0] : wr.row[AW-1:0];
      assign ram_wr_data = clearing ? '0 : wr.data;

      sic_ram #(
         .ADDR_BITS (AW),
         .DATA_BITS (sic_pkg::PAIR_BITS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_wr_en),
         .wr_addr (ram_wr_addr),
         .wr_data (ram_wr_data),
         .rd_addr (row[AW-1:0]),
         .rd_data (rd_data)
      );

      sic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_item  (chain[lv-1]),
         .in_row   (row),
         .in_side  (side),
         .rd_data  (rd_data),
         .wr       (wr),
         .out_item (chain[lv]),
         .busy     (busy_vec[lv])
      );
   end

   // output stage: root count, running total and sticky overflow
   sic_pkg::item_type                chain_out;
   logic [sic_pkg::COUNT_BITS-1:0]   root_ff, root_in;
   logic [sic_pkg::TOTAL_BITS-1:0]   total_ff, total_in;
   logic                             ovf_seen_ff, ovf_seen_in;
   logic [sic_pkg::COUNT_BITS-1:0]   base_root;
   logic [sic_pkg::TOTAL_BITS-1:0]   base_total;
   logic                             base_ovf;
   logic                             root_sat;
   logic [sic_pkg::TOTAL_BITS:0]     tot_sum;
   rsp_type                          entry;

   assign chain_out = chain[VB];

   always_comb begin
      base_root   = chain_out.first ? '0 : root_ff;
      base_total  = chain_out.first ? '0 : total_ff;
      base_ovf    = chain_out.first ? 1'b0 : ovf_seen_ff;
      root_sat    = (base_root == sic_pkg::COUNT_MAX);
      root_in     = root_sat ? base_root : base_root + 1'b1;
      tot_sum     = {1'b0, base_total} + (sic_pkg::TOTAL_BITS + 1)'(chain_out.acc);
      total_in    = tot_sum[sic_pkg::TOTAL_BITS] ? '1 : tot_sum[sic_pkg::TOTAL_BITS-1:0];
      ovf_seen_in = base_ovf | chain_out.ovf | root_sat | tot_sum[sic_pkg::TOTAL_BITS];
      entry.ovf     = ovf_seen_in;
      entry.total   = total_in;
      entry.greater = chain_out.acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff     <= '0;
         total_ff    <= '0;
         ovf_seen_ff <= 1'b0;
      end else if (chain_out.valid) begin
         root_ff     <= root_in;
         total_ff    <= total_in;
         ovf_seen_ff <= ovf_seen_in;
      end
   end

   // result queue, sized by the credit limit so it cannot overflow
   rsp_type              fifo_mem [OUT_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FCNT_BITS-1:0] fifo_cnt_ff, fifo_cnt_in;
   rsp_type              head;

   assign rsp_accept = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign head       = fifo_mem[rd_ptr_ff];
   assign rsp_tdata  = {head.total, head.greater};
   assign rsp_tuser  = head.ovf;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (chain_out.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rsp_accept) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({chain_out.valid, rsp_accept})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + 1'b1;
         2'b01:   fifo_cnt_in = fifo_cnt_ff - 1'b1;
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
      case ({req_accept, rsp_accept})
         2'b10:   outstanding_in = outstanding_ff + 1'b1;
         2'b01:   outstanding_in = outstanding_ff - 1'b1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fifo_cnt_ff    <= '0;
         outstanding_ff <= '0;
      end else begin
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         fifo_cnt_ff    <= fifo_cnt_in;
         outstanding_ff <= outstanding_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_out.valid) begin
         fifo_mem[wr_ptr_ff] <= entry;
      end
   end

   // checks
   `SIC_ASSERT_IMPL(a_fifo_room, chain_out.valid, fifo_cnt_ff < FCNT_BITS'(OUT_DEPTH), "result queue overrun")
   `SIC_ASSERT_IMPL(a_quiet_clear, state_ff == ST_CLEAR, !(|busy_vec), "item in chain during clearing pass")
   `SIC_ASSERT_NEXT(a_first_holds, req_accept && req_tuser[0], !req_tready, "input taken behind a first value")
   `SIC_ASSERT_IMPL(a_rsp_owed, rsp_tvalid, outstanding_ff != '0, "result without an owed transaction")

endmodule

/* hdl/sic_ram.sv */
// Simple dual-port row store with registered read, one per tree level.
module sic_ram #(
   parameter int ADDR_BITS = 1,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write first in code order, read returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sic_cell.sv */
// One tree level: sums the right sibling and bumps the path node of each item.
module sic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  sic_pkg::item_type             in_item,
   input  logic [sic_pkg::ROW_BITS-1:0]  in_row,
   input  logic                          in_side,
   input  logic [sic_pkg::PAIR_BITS-1:0] rd_data,
   output sic_pkg::wr_type               wr,
   output sic_pkg::item_type             out_item,
   output logic                          busy
);

   sic_pkg::item_type             s1_item_ff;
   logic [sic_pkg::ROW_BITS-1:0]  s1_row_ff;
   logic                          s1_side_ff;
   logic                          lw_valid_ff;
   logic [sic_pkg::ROW_BITS-1:0]  lw_row_ff;
   logic [sic_pkg::PAIR_BITS-1:0] lw_data_ff;
   logic [sic_pkg::PAIR_BITS-1:0] lw_data_in;
   sic_pkg::item_type             out_item_ff;
   sic_pkg::item_type             out_item_in;

   logic [sic_pkg::PAIR_BITS-1:0]    pair;
   logic [sic_pkg::COUNT_BITS-1:0]   left_cnt;
   logic [sic_pkg::COUNT_BITS-1:0]   right_cnt;
   logic [sic_pkg::COUNT_BITS-1:0]   path_cnt;
   logic [sic_pkg::COUNT_BITS-1:0]   path_new;
   logic [sic_pkg::COUNT_BITS-1:0]   sib_cnt;
   logic                             path_sat;
   logic [sic_pkg::ACC_SUM_BITS-1:0] acc_sum;
   logic                             acc_sat;

   // row read issued with the item, data lands alongside stage one
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff.valid  <= 1'b0;
         out_item_ff.valid <= 1'b0;
         lw_valid_ff       <= 1'b0;
      end else begin
         s1_item_ff  <= in_item;
         out_item_ff <= out_item_in;
         lw_valid_ff <= s1_item_ff.valid;
      end
      s1_row_ff  <= in_row;
      s1_side_ff <= in_side;
      lw_row_ff  <= s1_row_ff;
      lw_data_ff <= lw_data_in;
   end

   // forward the row written last cycle, the store still returns old data
   always_comb begin
      pair      = (lw_valid_ff && (lw_row_ff == s1_row_ff)) ? lw_data_ff : rd_data;
      left_cnt  = pair[sic_pkg::COUNT_BITS-1:0];
      right_cnt = pair[sic_pkg::PAIR_BITS-1:sic_pkg::COUNT_BITS];
      path_cnt  = s1_side_ff ? right_cnt : left_cnt;
      path_sat  = (path_cnt == sic_pkg::COUNT_MAX);
      path_new  = path_sat ? path_cnt : path_cnt + 1'b1;
      // a left child sees everything under its right sibling as greater
      sib_cnt   = s1_side_ff ? '0 : right_cnt;
      acc_sum   = sic_pkg::ACC_SUM_BITS'(s1_item_ff.acc) + sic_pkg::ACC_SUM_BITS'(sib_cnt);
      acc_sat   = acc_sum > sic_pkg::ACC_SUM_BITS'(sic_pkg::GREATER_MAX);
      lw_data_in = s1_side_ff ? {path_new, left_cnt} : {right_cnt, path_new};

      out_item_in     = s1_item_ff;
      out_item_in.acc = acc_sat ? sic_pkg::GREATER_MAX : sic_pkg::GREATER_BITS'(acc_sum);
      out_item_in.ovf = s1_item_ff.ovf | path_sat | acc_sat;
   end

   // updated row goes back to the store
   assign wr.en    = s1_item_ff.valid;
   assign wr.row   = s1_row_ff;
   assign wr.data  = lw_data_in;

   assign out_item = out_item_ff;
   assign busy     = s1_item_ff.valid | out_item_ff.valid;

endmodule
